@@ src/sxfc_pkg.sv @@
`default_nettype none

package sxfc_pkg;

  localparam int DATA_W  = 8;
  localparam int COUNT_W = 9;
  localparam int TOTAL_W = COUNT_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = 9'd511;
  localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = 10'd7;
  localparam logic [TOTAL_W-1:0] SHORT_LIMIT    = 10'd4;
  localparam logic [COUNT_W-1:0] IDX_FIRST      = 9'd0;
  localparam logic [COUNT_W-1:0] IDX_LENGTH     = 9'd3;
  localparam logic [COUNT_W-1:0] IDX_SUM_START  = 9'd4;

  localparam logic [DATA_W-1:0] HEAD_RESET = 8'hfe;
  localparam logic [DATA_W-1:0] TAIL_RESET = 8'hff;

  // register index, taken from paddr bit 2
  localparam logic REG_HEAD = 1'b0;
  localparam logic REG_TAIL = 1'b1;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHORT  = 3'd1,
    ST_HEAD   = 3'd2,
    ST_TAIL   = 3'd3,
    ST_LENGTH = 3'd4,
    ST_SUM    = 3'd5,
    ST_XOR    = 3'd6
  } status_t;

  // frame_ok in bit 0, status above it
  typedef struct packed {
    status_t status;
    logic    frame_ok;
  } verdict_t;

endpackage

`default_nettype wire

@@ src/sxfc_track.sv @@
`default_nettype none

module sxfc_track (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         fire,
  input  wire [sxfc_pkg::DATA_W-1:0]  data_byte,
  input  wire                         last_byte,
  input  wire [sxfc_pkg::DATA_W-1:0]  head_byte,
  input  wire [sxfc_pkg::DATA_W-1:0]  tail_byte,
  output logic                        verdict_valid,
  output sxfc_pkg::verdict_t          verdict
);
  import sxfc_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [DATA_W-1:0]  first_r, first_nxt;
  logic [DATA_W-1:0]  len_r, len_nxt;
  logic [DATA_W-1:0]  rec0_r, rec1_r, rec2_r;
  logic [DATA_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0]  xor_r, xor_nxt;
  logic [TOTAL_W-1:0] total;
  status_t            st;

  always_comb begin
    first_nxt = (count_r == IDX_FIRST)  ? data_byte : first_r;
    len_nxt   = (count_r == IDX_LENGTH) ? data_byte : len_r;
    // byte leaving the three-byte window joins the checksums from index 1 on
    if (count_r >= IDX_SUM_START) begin
      sum_nxt = sum_r + rec2_r;
      xor_nxt = xor_r ^ rec2_r;
    end else begin
      sum_nxt = sum_r;
      xor_nxt = xor_r;
    end
    count_nxt = (count_r < COUNT_MAX) ? count_r + 1'b1 : count_r;
    total     = {1'b0, count_r} + 1'b1;
  end

  // on the final byte: rec1_r is the sum byte, rec0_r the xor byte
  always_comb begin
    if (total <= SHORT_LIMIT) begin
      st = ST_SHORT;
    end else if (first_r != head_byte) begin
      st = ST_HEAD;
    end else if (data_byte != tail_byte) begin
      st = ST_TAIL;
    end else if (total < FRAME_OVERHEAD ||
                 {{(TOTAL_W-DATA_W){1'b0}}, len_r} != total - FRAME_OVERHEAD) begin
      st = ST_LENGTH;
    end else if (sum_nxt != rec1_r) begin
      st = ST_SUM;
    end else if (xor_nxt != rec0_r) begin
      st = ST_XOR;
    end else begin
      st = ST_OK;
    end
  end

  assign verdict_valid    = fire && last_byte;
  assign verdict.status   = st;
  assign verdict.frame_ok = (st == ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last_byte)) begin
      count_r <= '0;
      first_r <= '0;
      len_r   <= '0;
      rec0_r  <= '0;
      rec1_r  <= '0;
      rec2_r  <= '0;
      sum_r   <= '0;
      xor_r   <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      rec0_r  <= data_byte;
      rec1_r  <= rec0_r;
      rec2_r  <= rec1_r;
      sum_r   <= sum_nxt;
      xor_r   <= xor_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sxfc_out_reg.sv @@
`default_nettype none

module sxfc_out_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  sxfc_pkg::verdict_t  verdict,
  output logic                space,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata
);
  import sxfc_pkg::*;

  logic     valid_r;
  verdict_t data_r;

  // free when empty or when the held verdict transfers this cycle
  assign space      = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {{(8 - $bits(verdict_t)){1'b0}}, data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= verdict;
    end
  end

endmodule

`default_nettype wire

@@ src/sum_xor_frame_checker.sv @@
// channel | signals                                  | payload
// in      | in_tvalid, in_tready, in_tdata, in_tlast | data_byte[7:0], last_byte on tlast
// out     | out_tvalid, out_tready, out_tdata        | frame_ok[0], status[3:1]
// cfg     | cfg_psel .. cfg_pready                   | head_byte @0x0, tail_byte @0x4
//
// One byte per cycle; the verdict for the final byte appears in the output
// register the next cycle. Window shift, checksum adder and XOR, and the status
// compare all feed that register combinationally. rst_n (synchronous) clears
// frame state and restores the register defaults. in_tready drops only while a
// verdict is held and out_tready is low.
`default_nettype none

module sum_xor_frame_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // data_byte[7:0]
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // frame_ok[0], status[3:1], zero[7:4]
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sxfc_pkg::*;

  logic              reg_sel, unused_addr;
  logic [DATA_W-1:0] head_byte_r, tail_byte_r;
  logic              fire, space, verdict_valid;
  logic              cfg_wr;
  verdict_t          verdict;

  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel     = cfg_paddr[2];
  // byte offset within a word is ignored
  assign unused_addr = ^cfg_paddr[1:0];

  always_comb begin
    cfg_prdata = '0;
    unique case (reg_sel)
      REG_HEAD: cfg_prdata[DATA_W-1:0] = head_byte_r;
      REG_TAIL: cfg_prdata[DATA_W-1:0] = tail_byte_r;
      default:  cfg_prdata = {31'd0, unused_addr & 1'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_byte_r <= HEAD_RESET;
      tail_byte_r <= TAIL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_HEAD: head_byte_r <= cfg_pwdata[DATA_W-1:0];
        REG_TAIL: tail_byte_r <= cfg_pwdata[DATA_W-1:0];
        default:  ;
      endcase
    end
  end

  assign in_tready = space;
  assign fire      = in_tvalid && in_tready;

  sxfc_track u_track (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .data_byte     (in_tdata),
    .last_byte     (in_tlast),
    .head_byte     (head_byte_r),
    .tail_byte     (tail_byte_r),
    .verdict_valid (verdict_valid),
    .verdict       (verdict)
  );

  sxfc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (verdict_valid),
    .verdict    (verdict),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
